>>> hw/rtl/bmpd_pkg.sv
// Shared constants and types for the BMP pixel stream decoder.
// Holds size defaults, pixel format codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bmpd_pkg;

  // Size defaults for the top level parameters
  localparam int unsigned MAX_WIDTH_DEF     = 4096;
  localparam int unsigned MAX_HEIGHT_DEF    = 4096;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  // Register port geometry
  localparam int unsigned REG_DW = 32;
  localparam int unsigned REG_AW = 4;

  // Field widths of the configuration registers
  localparam int unsigned FMT_W  = 3;
  localparam int unsigned SIZE_W = 13;

  // Entries loaded in the 4-bit palette format
  localparam int unsigned PAL4_ENTRIES = 16;

  typedef logic [FMT_W-1:0]  fmt_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [1:0]        reg_idx_t;

  // Pixel format codes
  localparam fmt_t FMT_PAL4   = 3'd0;
  localparam fmt_t FMT_PAL8   = 3'd1;
  localparam fmt_t FMT_RGB555 = 3'd2;
  localparam fmt_t FMT_RGB24  = 3'd3;
  localparam fmt_t FMT_RGB32  = 3'd4;

  // Register indexes (byte address is 4 times the index)
  localparam reg_idx_t REG_FORMAT = 2'd0;
  localparam reg_idx_t REG_WIDTH  = 2'd1;
  localparam reg_idx_t REG_HEIGHT = 2'd2;

endpackage

>>> hw/rtl/bmpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while read enable is low. No dependencies.
`timescale 1ns / 1ps

module bmpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bmp_pixel_stream_decoder.sv
// Top level of the BMP pixel stream decoder: APB-style register port, byte
// input channel, pixel output channel. Depends on bmpd_pkg and bmpd_ram.
`timescale 1ns / 1ps

// Usage
//   Program pixel_format, image_width and image_height over the register
//   port while the block is idle; any register write restarts the image.
//   Then stream the BMP body (palette, then pixel rows with padding) one
//   word per cycle on in_*. Decoded pixels leave on out_* as blue, green,
//   red and extra_byte, with image_done on the final pixel of the image and
//   run_last on the last pixel that an input word caused.
//   A pixel passes from the word that completes it through the lookup
//   stage and the output register. Throughput: one input word per cycle
//   unless the receiver stalls, in all formats but 4-bit palette, where
//   a two-pixel word drops in_ready for its second read (one RAM read port).
//   Palette bytes are gathered into whole entries and written once per
//   entry; each palette lookup is one RAM read.
//   Reset selects 24-bit format, 1x1 image, counters cleared. The palette
//   RAM is not cleared and must be loaded by the stream before use.
//   When the receiver stalls, the output register and one pipeline stage
//   fill, then in_ready drops until the output drains.
module bmp_pixel_stream_decoder #(
  parameter int unsigned MAX_WIDTH     = bmpd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT    = bmpd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned PALETTE_DEPTH = bmpd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bmpd_pkg::REG_AW-1:0] paddr,
  input  logic [bmpd_pkg::REG_DW-1:0] pwdata,
  output logic [bmpd_pkg::REG_DW-1:0] prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_extra_byte,
  output logic                       out_image_done,
  output logic                       out_run_last
);

  import bmpd_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned EWW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned EHW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PAW  = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNTW = PAW + 2;
  localparam int unsigned TOTW = CNTW + 1;
  localparam logic [TOTW-1:0] TOTAL_PAL8 = TOTW'(PALETTE_DEPTH * 4);
  localparam logic [TOTW-1:0] TOTAL_PAL4 = TOTW'(PAL4_ENTRIES * 4);

  // Configuration registers
  fmt_t  fmt_r, fmt_nxt;
  size_t width_r, width_nxt;
  size_t height_r, height_nxt;

  // Stream position state
  logic            loading_r, loading_nxt;
  logic [CNTW-1:0] pcount_r, pcount_nxt;
  logic [1:0]      bip_r, bip_nxt;
  logic [23:0]     gather_r, gather_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [1:0]      pad_r, pad_nxt;
  logic            pend_r, pend_nxt;
  logic [3:0]      lo_r, lo_nxt;

  // Lookup stage (RAM read in flight) and output register
  logic        s1_valid_r;
  logic        s1_use_ram_r;
  logic [31:0] s1_px_r;
  logic        s1_done_r;
  logic        s1_last_r;
  logic        out_valid_r;
  logic [31:0] out_px_r;
  logic        out_done_r;
  logic        out_last_r;

  // Stage control
  logic        cfg_we, cfg_hit;
  fmt_t        fmt_new;
  logic        s1_adv, s1_can;
  logic        fire_in, fire_pend;
  logic        px_go, s1_load, s1_use_nxt, s1_last_nxt, s1_done_nxt;
  logic [31:0] s1_px_nxt, s1_data;
  logic        ram_re, pal_we;
  logic [PAW-1:0] ram_raddr, pal_waddr;
  logic [31:0] ram_rdata;

  // Geometry helpers
  logic [EWW-1:0] eff_w;
  logic [EHW-1:0] eff_h;
  logic [2:0]     w_plus1;
  logic [1:0]     rb_lo, row_pad;
  logic [2:0]     bpp;
  logic           col_last, row_last, fmt_is_pal;
  logic [TOTW-1:0] pal_total;

  // Clamp width and height to the supported range
  always_comb begin
    if (width_r == '0) begin
      eff_w = EWW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = EHW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = EHW'(MAX_HEIGHT);
    end else begin
      eff_h = EHW'(height_r);
    end
  end

  // Row padding: only the low two bits of the row byte count matter
  assign w_plus1 = eff_w[2:0] + 3'd1;
  always_comb begin
    priority if (fmt_r == FMT_PAL4) begin
      rb_lo = w_plus1[2:1];
    end else if (fmt_r == FMT_PAL8) begin
      rb_lo = eff_w[1:0];
    end else if (fmt_r == FMT_RGB555) begin
      rb_lo = {eff_w[0], 1'b0};
    end else if (fmt_r == FMT_RGB24) begin
      rb_lo = 2'({eff_w[1:0], 1'b0} + {1'b0, eff_w[1:0]});
    end else begin
      rb_lo = 2'd0;
    end
  end
  assign row_pad = 2'd0 - rb_lo;

  assign bpp = (fmt_r == FMT_RGB555) ? 3'd2 :
               (fmt_r == FMT_RGB24)  ? 3'd3 : 3'd4;
  assign fmt_is_pal = (fmt_r == FMT_PAL4) || (fmt_r == FMT_PAL8);
  assign pal_total  = (fmt_r == FMT_PAL4) ? TOTAL_PAL4 : TOTAL_PAL8;
  assign col_last   = (EWW'(col_r) + EWW'(1)) >= eff_w;
  assign row_last   = (EHW'(row_r) + EHW'(1)) >= eff_h;

  // Register port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_hit = cfg_we && ((paddr[3:2] == REG_FORMAT) || (paddr[3:2] == REG_WIDTH) ||
                              (paddr[3:2] == REG_HEIGHT));
  assign fmt_new = (cfg_we && paddr[3:2] == REG_FORMAT) ? pwdata[FMT_W-1:0] : fmt_r;

  always_comb begin
    fmt_nxt    = fmt_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_FORMAT: fmt_nxt    = pwdata[FMT_W-1:0];
        REG_WIDTH:  width_nxt  = pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[SIZE_W-1:0];
        default:    fmt_nxt    = fmt_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FORMAT: prdata = REG_DW'(fmt_r);
      REG_WIDTH:  prdata = REG_DW'(width_r);
      REG_HEIGHT: prdata = REG_DW'(height_r);
      default:    prdata = '0;
    endcase
  end

  // Pipeline handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_can    = !s1_valid_r || s1_adv;
  assign in_ready  = s1_can && !pend_r;
  assign fire_in   = in_valid && in_ready;
  assign fire_pend = pend_r && s1_can;

  // Front stage: parse the word, load the palette, advance position, issue palette read
  always_comb begin
    loading_nxt = loading_r;
    pcount_nxt  = pcount_r;
    bip_nxt     = bip_r;
    gather_nxt  = gather_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    pad_nxt     = pad_r;
    pend_nxt    = pend_r;
    lo_nxt      = lo_r;
    px_go       = 1'b0;
    s1_use_nxt  = 1'b0;
    s1_last_nxt = 1'b1;
    s1_px_nxt   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    pal_we      = 1'b0;
    pal_waddr   = pcount_r[CNTW-1:2];

    if (fire_pend) begin
      // second pixel of a 4-bit word: low nibble
      px_go      = 1'b1;
      s1_use_nxt = 1'b1;
      ram_re     = 1'b1;
      ram_raddr  = PAW'(lo_r);
      pend_nxt   = 1'b0;
    end else if (fire_in) begin
      if (pad_r != 2'd0) begin
        // drop row padding
        pad_nxt = pad_r - 2'd1;
      end else if (loading_r) begin
        // gather palette bytes, write the entry on its last byte
        gather_nxt[8*pcount_r[1:0] +: 8] = in_data_byte;
        pal_we = (pcount_r[1:0] == 2'd3);
        if ((TOTW'(pcount_r) + TOTW'(1)) >= pal_total) begin
          pcount_nxt  = '0;
          loading_nxt = 1'b0;
        end else begin
          pcount_nxt = pcount_r + CNTW'(1);
        end
      end else if (fmt_r == FMT_PAL4) begin
        px_go       = 1'b1;
        s1_use_nxt  = 1'b1;
        ram_re      = 1'b1;
        ram_raddr   = PAW'(in_data_byte[7:4]);
        pend_nxt    = !col_last;
        s1_last_nxt = col_last;
        lo_nxt      = in_data_byte[3:0];
      end else if (fmt_r == FMT_PAL8) begin
        px_go      = 1'b1;
        s1_use_nxt = 1'b1;
        ram_re     = 1'b1;
        ram_raddr  = PAW'(in_data_byte);
      end else if ((3'(bip_r) + 3'd1) < bpp) begin
        // hold partial direct-color pixel
        gather_nxt[8*bip_r +: 8] = in_data_byte;
        bip_nxt = bip_r + 2'd1;
      end else begin
        px_go   = 1'b1;
        bip_nxt = 2'd0;
        priority if (bpp == 3'd2) begin
          s1_px_nxt = {8'h00,
                       in_data_byte[6:2], 3'b000,
                       in_data_byte[1:0], gather_r[7:5], 3'b000,
                       gather_r[4:0], 3'b000};
        end else if (bpp == 3'd3) begin
          s1_px_nxt = {8'h00, in_data_byte, gather_r[15:0]};
        end else begin
          s1_px_nxt = {in_data_byte, gather_r};
        end
      end
    end

    // Advance column and row after each pixel
    s1_load     = px_go;
    s1_done_nxt = px_go && col_last && row_last;
    if (px_go) begin
      if (col_last) begin
        col_nxt = '0;
        pad_nxt = row_pad;
        if (row_last) begin
          row_nxt     = '0;
          loading_nxt = fmt_is_pal;
          pcount_nxt  = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end

    // Restart the image on any register write
    if (cfg_hit) begin
      loading_nxt = (fmt_new == FMT_PAL4) || (fmt_new == FMT_PAL8);
      pcount_nxt  = '0;
      bip_nxt     = 2'd0;
      gather_nxt  = '0;
      col_nxt     = '0;
      row_nxt     = '0;
      pad_nxt     = 2'd0;
      pend_nxt    = 1'b0;
    end
  end

  // Palette memory
  bmpd_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(pal_waddr),
    .wdata({in_data_byte, gather_r}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign s1_data = s1_use_ram_r ? ram_rdata : s1_px_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_RGB24;
      width_r     <= SIZE_W'(1);
      height_r    <= SIZE_W'(1);
      loading_r   <= 1'b0;
      pcount_r    <= '0;
      bip_r       <= 2'd0;
      gather_r    <= '0;
      col_r       <= '0;
      row_r       <= '0;
      pad_r       <= 2'd0;
      pend_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fmt_r     <= fmt_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      loading_r <= loading_nxt;
      pcount_r  <= pcount_nxt;
      bip_r     <= bip_nxt;
      gather_r  <= gather_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pad_r     <= pad_nxt;
      pend_r    <= pend_nxt;
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    if (s1_load) begin
      s1_use_ram_r <= s1_use_nxt;
      s1_px_r      <= s1_px_nxt;
      s1_done_r    <= s1_done_nxt;
      s1_last_r    <= s1_last_nxt;
    end
    if (s1_adv) begin
      out_px_r   <= s1_data;
      out_done_r <= s1_done_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blue       = out_px_r[7:0];
  assign out_green      = out_px_r[15:8];
  assign out_red        = out_px_r[23:16];
  assign out_extra_byte = out_px_r[31:24];
  assign out_image_done = out_done_r;
  assign out_run_last   = out_last_r;

  // A stalled lookup stage must see its RAM data held
  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> $stable(ram_rdata))
    else $error("palette read data changed under a stalled lookup");

  // Padding words produce no pixel
  a_pad_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire_in && !fire_pend && (pad_r != 2'd0) |=> !s1_valid_r)
    else $error("padding word produced a pixel");

  // The final pixel of an image closes its word's run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("image_done without run_last");

  // A pending low nibble only exists in 4-bit mode outside the palette load
  a_pend_mode: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (fmt_r == FMT_PAL4) && !loading_r)
    else $error("pending nibble outside 4-bit pixel phase");

endmodule
